@@ src/sdnr_pkg.sv @@
package sdnr_pkg;

    localparam int CharWidth    = 8;
    localparam int VerdictWidth = 3;

    localparam logic [CharWidth-1:0] CharNul   = 8'h00;
    localparam logic [CharWidth-1:0] CharZero  = 8'h30;
    localparam logic [CharWidth-1:0] CharOne   = 8'h31;
    localparam logic [CharWidth-1:0] CharNine  = 8'h39;
    localparam logic [CharWidth-1:0] CharComma = 8'h2C;
    localparam logic [CharWidth-1:0] CharPlus  = 8'h2B;
    localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

    typedef enum logic [2:0] {
        CL_ZERO  = 3'd0,
        CL_DIGIT = 3'd1,
        CL_COMMA = 3'd2,
        CL_SIGN  = 3'd3,
        CL_OTHER = 3'd4
    } char_class_t;

    typedef enum logic [VerdictWidth-1:0] {
        V_REJECT = 3'd0,
        V_INT    = 3'd1,
        V_DEC    = 3'd2,
        V_SINT   = 3'd3,
        V_SDEC   = 3'd4
    } verdict_t;

    function automatic char_class_t classify(input logic [CharWidth-1:0] ch);
        char_class_t cl;
        if (ch == CharZero)
            cl = CL_ZERO;
        else if (ch >= CharOne && ch <= CharNine)
            cl = CL_DIGIT;
        else if (ch == CharComma)
            cl = CL_COMMA;
        else if (ch == CharPlus || ch == CharMinus)
            cl = CL_SIGN;
        else
            cl = CL_OTHER;
        return cl;
    endfunction

endpackage

@@ src/signed_decimal_number_recognizer.sv @@
// Channel  | Handshake          | Payload          | Direction
// ---------+--------------------+------------------+----------
// input    | in_valid, in_stall | char_code [7:0]  | in
// output   | out_valid,out_stall| verdict [2:0]    | out
//
// Each item is taken into an input register; from there its state transition
// is done and, for a terminator, the verdict is loaded into the output
// register: one item per cycle unless a terminator is held by a stalled, full output register.
// Reset (rst_n, asynchronous) empties both registers and sets the start state.
// Only a terminator waiting on a full, stalled output register holds the
// input; other characters keep flowing while a verdict waits.
module signed_decimal_number_recognizer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sdnr_pkg::CharWidth-1:0]      char_code,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sdnr_pkg::VerdictWidth-1:0]   verdict
);

    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_SIGN   = 4'd1,
        ST_INT    = 4'd2,
        ST_FRAC   = 4'd3,
        ST_COMMA  = 4'd4,
        ST_FRACZ  = 4'd5,
        ST_SINT   = 4'd6,
        ST_SFRAC  = 4'd7,
        ST_SCOMMA = 4'd8,
        ST_SFRACZ = 4'd9,
        ST_SZERO  = 4'd10,
        ST_ZERO   = 4'd11,
        ST_ZEROS  = 4'd12,
        ST_TRAP   = 4'd13
    } scan_state_t;

    function automatic scan_state_t next_state(input scan_state_t st,
                                               input sdnr_pkg::char_class_t cl);
        scan_state_t nx;
        nx = ST_TRAP;
        case (st)
            ST_START:
            begin
                case (cl)
                    sdnr_pkg::CL_ZERO:  nx = ST_ZERO;
                    sdnr_pkg::CL_DIGIT: nx = ST_INT;
                    sdnr_pkg::CL_SIGN:  nx = ST_SIGN;
                    default:            nx = ST_TRAP;
                endcase
            end
            ST_SIGN:
            begin
                case (cl)
                    sdnr_pkg::CL_ZERO:  nx = ST_SZERO;
                    sdnr_pkg::CL_DIGIT: nx = ST_SINT;
                    default:            nx = ST_TRAP;
                endcase
            end
            ST_INT, ST_ZERO, ST_ZEROS:
            begin
                case (cl)
                    sdnr_pkg::CL_ZERO:  nx = (st == ST_INT) ? ST_INT : ST_ZEROS;
                    sdnr_pkg::CL_DIGIT: nx = ST_INT;
                    sdnr_pkg::CL_COMMA: nx = ST_COMMA;
                    default:            nx = ST_TRAP;
                endcase
            end
            ST_FRAC, ST_COMMA, ST_FRACZ:
            begin
                case (cl)
                    sdnr_pkg::CL_ZERO:  nx = ST_FRACZ;
                    sdnr_pkg::CL_DIGIT: nx = ST_FRAC;
                    default:            nx = ST_TRAP;
                endcase
            end
            ST_SINT, ST_SZERO:
            begin
                case (cl)
                    sdnr_pkg::CL_ZERO:  nx = (st == ST_SINT) ? ST_SINT : ST_SZERO;
                    sdnr_pkg::CL_DIGIT: nx = ST_SINT;
                    sdnr_pkg::CL_COMMA: nx = ST_SCOMMA;
                    default:            nx = ST_TRAP;
                endcase
            end
            ST_SFRAC, ST_SCOMMA, ST_SFRACZ:
            begin
                case (cl)
                    sdnr_pkg::CL_ZERO:  nx = ST_SFRACZ;
                    sdnr_pkg::CL_DIGIT: nx = ST_SFRAC;
                    default:            nx = ST_TRAP;
                endcase
            end
            default:  nx = ST_TRAP;
        endcase
        return nx;
    endfunction

    function automatic sdnr_pkg::verdict_t final_verdict(input scan_state_t st);
        sdnr_pkg::verdict_t v;
        case (st)
            ST_INT, ST_ZERO: v = sdnr_pkg::V_INT;
            ST_FRAC:         v = sdnr_pkg::V_DEC;
            ST_SINT:         v = sdnr_pkg::V_SINT;
            ST_SFRAC:        v = sdnr_pkg::V_SDEC;
            default:         v = sdnr_pkg::V_REJECT;
        endcase
        return v;
    endfunction

    logic                           in_valid_reg;
    logic [sdnr_pkg::CharWidth-1:0] char_reg;
    scan_state_t                    scan_state_reg;
    scan_state_t                    scan_state_next;
    logic                           out_valid_reg;
    sdnr_pkg::verdict_t             verdict_reg;

    logic is_term;
    logic out_free;
    logic advance;
    logic in_accept;

    assign is_term   = (char_reg == sdnr_pkg::CharNul);
    assign out_free  = !out_valid_reg || !out_stall;
    // A terminator needs room in the output register; other characters do not.
    assign advance   = in_valid_reg && (!is_term || out_free);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (is_term)
            scan_state_next = ST_START;
        else
            scan_state_next = next_state(scan_state_reg, sdnr_pkg::classify(char_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            scan_state_reg <= ST_START;
            out_valid_reg  <= 1'b0;
            verdict_reg    <= sdnr_pkg::V_REJECT;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                scan_state_reg <= scan_state_next;

            if (advance && is_term)
            begin
                out_valid_reg <= 1'b1;
                verdict_reg   <= final_verdict(scan_state_reg);
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            char_reg <= char_code;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_term |=> scan_state_reg == ST_START && out_valid)
        else $error("terminator did not restart the scan or load a verdict");

    a_stall_only_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> is_term && out_valid_reg && out_stall)
        else $error("input stalled without a blocked terminator");

    a_trap_absorbs: assert property (@(posedge clk) disable iff (!rst_n)
        scan_state_reg == ST_TRAP && advance && !is_term
        |=> scan_state_reg == ST_TRAP)
        else $error("trap state left on a nonzero character");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(scan_state_reg))
        else $error("scan state changed without an item");

endmodule

@@ test/signed_decimal_number_recognizer_tb.sv @@
`timescale 1ns / 100ps

module signed_decimal_number_recognizer_tb;

    localparam int CycleLimit = 200_000;

    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_SIGN   = 4'd1,
        ST_INT    = 4'd2,
        ST_FRAC   = 4'd3,
        ST_COMMA  = 4'd4,
        ST_FRACZ  = 4'd5,
        ST_SINT   = 4'd6,
        ST_SFRAC  = 4'd7,
        ST_SCOMMA = 4'd8,
        ST_SFRACZ = 4'd9,
        ST_SZERO  = 4'd10,
        ST_ZERO   = 4'd11,
        ST_ZEROS  = 4'd12,
        ST_TRAP   = 4'd13
    } scan_state_t;

    // Keeps its own copy of the recognizer state and queues one verdict per terminator.
    class verdict_scoreboard;
        scan_state_t        state;
        sdnr_pkg::verdict_t expected_q[$];
        int                 errors;

        function new();
            state  = ST_START;
            errors = 0;
        endfunction

        function scan_state_t advance(scan_state_t s, logic [sdnr_pkg::CharWidth-1:0] ch);
            bit          is_zero;
            bit          is_nz;
            bit          is_comma;
            bit          is_sign;
            scan_state_t nx;
            is_zero  = (ch == sdnr_pkg::CharZero);
            is_nz    = (ch >= sdnr_pkg::CharOne) && (ch <= sdnr_pkg::CharNine);
            is_comma = (ch == sdnr_pkg::CharComma);
            is_sign  = (ch == sdnr_pkg::CharPlus) || (ch == sdnr_pkg::CharMinus);
            nx       = ST_TRAP;
            case (s)
                ST_START:
                begin
                    if (is_zero)
                        nx = ST_ZERO;
                    else if (is_nz)
                        nx = ST_INT;
                    else if (is_sign)
                        nx = ST_SIGN;
                end
                ST_SIGN:
                begin
                    if (is_zero)
                        nx = ST_SZERO;
                    else if (is_nz)
                        nx = ST_SINT;
                end
                ST_INT:
                begin
                    if (is_zero || is_nz)
                        nx = ST_INT;
                    else if (is_comma)
                        nx = ST_COMMA;
                end
                ST_ZERO, ST_ZEROS:
                begin
                    if (is_zero)
                        nx = ST_ZEROS;
                    else if (is_nz)
                        nx = ST_INT;
                    else if (is_comma)
                        nx = ST_COMMA;
                end
                ST_COMMA, ST_FRAC, ST_FRACZ:
                begin
                    if (is_zero)
                        nx = ST_FRACZ;
                    else if (is_nz)
                        nx = ST_FRAC;
                end
                ST_SINT:
                begin
                    if (is_zero || is_nz)
                        nx = ST_SINT;
                    else if (is_comma)
                        nx = ST_SCOMMA;
                end
                ST_SZERO:
                begin
                    if (is_zero)
                        nx = ST_SZERO;
                    else if (is_nz)
                        nx = ST_SINT;
                    else if (is_comma)
                        nx = ST_SCOMMA;
                end
                ST_SCOMMA, ST_SFRAC, ST_SFRACZ:
                begin
                    if (is_zero)
                        nx = ST_SFRACZ;
                    else if (is_nz)
                        nx = ST_SFRAC;
                end
                default:
                    nx = ST_TRAP;
            endcase
            return nx;
        endfunction

        function sdnr_pkg::verdict_t verdict_of(scan_state_t s);
            sdnr_pkg::verdict_t v;
            v = sdnr_pkg::V_REJECT;
            if (s == ST_INT || s == ST_ZERO)
                v = sdnr_pkg::V_INT;
            else if (s == ST_FRAC)
                v = sdnr_pkg::V_DEC;
            else if (s == ST_SINT)
                v = sdnr_pkg::V_SINT;
            else if (s == ST_SFRAC)
                v = sdnr_pkg::V_SDEC;
            return v;
        endfunction

        function void note_char(logic [sdnr_pkg::CharWidth-1:0] ch);
            if (ch == sdnr_pkg::CharNul)
            begin
                expected_q.push_back(verdict_of(state));
                state = ST_START;
            end
            else
                state = advance(state, ch);
        endfunction

        function void check_verdict(logic [sdnr_pkg::VerdictWidth-1:0] got);
            sdnr_pkg::verdict_t want;
            if (expected_q.size() == 0)
            begin
                $error("verdict: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                $error("verdict: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic [sdnr_pkg::CharWidth-1:0]    char_code = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [sdnr_pkg::VerdictWidth-1:0] verdict;

    int                             in_idle_pct  = 30;
    int                             out_idle_pct = 85;
    int                             cycle_count  = 0;
    logic [sdnr_pkg::CharWidth-1:0] word_buf[$];
    verdict_scoreboard              sb = new();

    signed_decimal_number_recognizer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_char(char_code);
        if (rst_n && out_valid && !out_stall)
            sb.check_verdict(verdict);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("signed_decimal_number_recognizer_tb: errors");
            $finish;
        end
    end

    task automatic send_char(input logic [sdnr_pkg::CharWidth-1:0] ch);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_buf();
        foreach (word_buf[i])
            send_char(word_buf[i]);
        send_char(sdnr_pkg::CharNul);
    endtask

    task automatic send_text(input string s);
        word_buf.delete();
        for (int i = 0; i < s.len(); i++)
            word_buf.push_back(s[i]);
        send_buf();
    endtask

    // Lower valid, then hold off until every verdict owed has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [sdnr_pkg::CharWidth-1:0] any_digit();
        return 8'(sdnr_pkg::CharZero + $urandom_range(9));
    endfunction

    function automatic logic [sdnr_pkg::CharWidth-1:0] nz_digit();
        return 8'(sdnr_pkg::CharOne + $urandom_range(8));
    endfunction

    function automatic logic [sdnr_pkg::CharWidth-1:0] any_sign();
        return $urandom_range(1) ? sdnr_pkg::CharPlus : sdnr_pkg::CharMinus;
    endfunction

    // Mostly well-formed numbers with random content; the rest are raw bytes,
    // empty words, lone signs, or numbers with one stray symbol inserted.
    task automatic build_word();
        int                             kind;
        int                             pos;
        logic [sdnr_pkg::CharWidth-1:0] junk;
        word_buf.delete();
        kind = $urandom_range(99);
        if (kind < 6)
        begin
            repeat ($urandom_range(1, 6))
                word_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        if (kind < 9)
            return;
        if (kind < 11)
        begin
            word_buf.push_back(any_sign());
            return;
        end
        if ($urandom_range(3) == 0)
            word_buf.push_back(any_sign());
        case ($urandom_range(3))
            0:
                word_buf.push_back(sdnr_pkg::CharZero);
            1:
            begin
                repeat ($urandom_range(2, 4))
                    word_buf.push_back(sdnr_pkg::CharZero);
                if ($urandom_range(1))
                    word_buf.push_back(any_digit());
            end
            default:
            begin
                word_buf.push_back(nz_digit());
                repeat ($urandom_range(0, 4))
                    word_buf.push_back(any_digit());
            end
        endcase
        if ($urandom_range(1))
        begin
            word_buf.push_back(sdnr_pkg::CharComma);
            repeat ($urandom_range(0, 4))
                word_buf.push_back(any_digit());
        end
        if (kind >= 80)
        begin
            pos = $urandom_range(word_buf.size());
            case ($urandom_range(3))
                0:       junk = any_sign();
                1:       junk = sdnr_pkg::CharComma;
                default: junk = 8'($urandom_range(1, 255));
            endcase
            word_buf.insert(pos, junk);
        end
    endtask

    task automatic run_phase(input int n_chars);
        int sent;
        sent = 0;
        while (sent < n_chars)
        begin
            build_word();
            sent += word_buf.size() + 1;
            send_buf();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("");
        send_text("0");
        send_text("-7,5");
        send_text("+0");
        send_text("00");
        send_text("0,5");
        word_buf.delete();
        word_buf.push_back(8'hFF);
        send_buf();
        send_text("4+");
        send_text(",");
        send_text("-3");

        run_phase(600);
        drain();

        in_idle_pct  = 85;
        out_idle_pct = 30;
        run_phase(600);
        drain();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_phase(600);
        drain();

        repeat (6) @(posedge clk);
        if (sb.errors == 0)
            $display("signed_decimal_number_recognizer_tb: clean");
        else
            $display("signed_decimal_number_recognizer_tb: errors");
        $finish;
    end

endmodule
